// ----- rtl/cursor_array_list_assert.svh -----
// Assertion macros shared by the cursor list checker.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef CURSOR_ARRAY_LIST_ASSERT_SVH
`define CURSOR_ARRAY_LIST_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CAL_ASSERT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cursor list check failed");

// Next-cycle implication, disabled during reset.
`define CAL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cursor list check failed");

`endif

// ----- rtl/cal_pkg.sv -----
// Shared types and constants of the cursor list.
// No dependencies; used by every module of the block.
package cal_pkg;

   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      CMD_INS_AFTER  = 4'd0,
      CMD_INS_BEFORE = 4'd1,
      CMD_REMOVE     = 4'd2,
      CMD_BEGIN      = 4'd3,
      CMD_END        = 4'd4,
      CMD_NEXT       = 4'd5,
      CMD_PRIOR      = 4'd6,
      CMD_MOVE       = 4'd7,
      CMD_CLEAR      = 4'd8
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_HOLD   = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_REMOVE = 2'd2
   } cell_mode_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      cell_mode_type      mode;
      logic [CNT_W-1:0]   slot;
      logic [DATA_W-1:0]  value;
      logic [IDX_W-1:0]   rd_old;
      logic [IDX_W-1:0]   rd_new;
   } cell_ctrl_type;

endpackage

// ----- rtl/cal_cell.sv -----
// One storage cell of the cursor list chain.
// Depends on cal_pkg for widths and the broadcast control struct.
module cal_cell (
   input  logic                         clock,
   input  cal_pkg::cell_ctrl_type       ctrl,
   input  logic [cal_pkg::IDX_W-1:0]    cell_index,
   input  logic [cal_pkg::DATA_W-1:0]   left_value,
   input  logic [cal_pkg::DATA_W-1:0]   right_value,
   output logic [cal_pkg::DATA_W-1:0]   value,
   output logic [cal_pkg::DATA_W-1:0]   old_pick,
   output logic [cal_pkg::DATA_W-1:0]   new_pick
);
   import cal_pkg::*;

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   logic [CNT_W-1:0]  index_ext;

   assign index_ext = {1'b0, cell_index};

   always_comb begin
      value_in = value_ff;
      case (ctrl.mode)
         MODE_INSERT: begin
            if (index_ext == ctrl.slot) begin
               value_in = ctrl.value;
            end else if (index_ext > ctrl.slot) begin
               value_in = left_value;
            end
         end
         MODE_REMOVE: begin
            if (index_ext >= ctrl.slot) begin
               value_in = right_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value    = value_ff;
   assign old_pick = (cell_index == ctrl.rd_old) ? value_ff : '0;
   assign new_pick = (cell_index == ctrl.rd_new) ? value_in : '0;

endmodule

// ----- rtl/cal_chain.sv -----
// Row of cursor list cells with neighbor links and the cursor read-out.
// Depends on cal_pkg and cal_cell.
module cal_chain (
   input  logic                         clock,
   input  cal_pkg::cell_ctrl_type       ctrl,
   output logic [cal_pkg::DATA_W-1:0]   old_value,
   output logic [cal_pkg::DATA_W-1:0]   new_value
);
   import cal_pkg::*;

   logic [DATA_W-1:0] cell_value [CAPACITY];
   logic [DATA_W-1:0] old_pick   [CAPACITY];
   logic [DATA_W-1:0] new_pick   [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_value;
      logic [DATA_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_left
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_right
         assign right_value = cell_value[i+1];
      end

      cal_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .cell_index  (IDX_W'(i)),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i]),
         .old_pick    (old_pick[i]),
         .new_pick    (new_pick[i])
      );
   end

   // Only the addressed cell drives nonzero, so an OR merges the picks.
   always_comb begin
      old_value = '0;
      new_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         old_value = old_value | old_pick[i];
         new_value = new_value | new_pick[i];
      end
   end

endmodule

// ----- rtl/cursor_array_list.sv -----
// Top level of the cursor list: command decode, count and cursor, result register.
// Depends on cal_pkg and cal_chain.
//
//  channel | dir | tdata                          | tuser
//  req     | in  | value, position                | command
//  rsp     | out | removed, cursor value, count,  | ok
//          |     | cursor pos, empty, full        |
//
// One item per clock while the result channel is not stalled: every command
// completes in the cycle it is accepted, carried out by the parallel shift
// across the cell chain and the cursor read-out OR tree behind it.
// Reset clears count, cursor and the result valid; element cells keep
// whatever they hold, and only entries below count are ever read.
// A stalled result holds in the output register; the next item is taken
// in the same cycle the held result is taken.
module cursor_array_list (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value[31:0], position[37:32], zero pad
   input  logic [3:0]  req_tuser,   // command[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // removed_value[31:0], cursor_value[63:32],
                                    // count[70:64], cursor_pos[76:71],
                                    // is_empty[77], is_full[78], zero pad
   output logic        rsp_tuser    // ok
);
   import cal_pkg::*;

   // list state
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  cursor_ff, cursor_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              ok_ff;
   logic [DATA_W-1:0] removed_ff;
   logic [DATA_W-1:0] cur_value_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic [IDX_W-1:0]  rsp_cursor_ff;

   // request fields
   cmd_type           cmd;
   logic [DATA_W-1:0] req_value;
   logic [IDX_W-1:0]  req_position;

   logic              accept;
   logic              empty;
   logic              full;
   logic              ok;
   logic [CNT_W-1:0]  cursor_ext;
   logic [CNT_W-1:0]  cursor_p1;
   logic [CNT_W-1:0]  count_m1;
   logic [DATA_W-1:0] old_value;
   logic [DATA_W-1:0] new_value;
   cell_ctrl_type     ctrl;

   assign cmd          = cmd_type'(req_tuser);
   assign req_value    = req_tdata[DATA_W-1:0];
   assign req_position = req_tdata[DATA_W +: IDX_W];

   // Take a new item whenever the result slot is free or being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign cursor_ext = {1'b0, cursor_ff};
   assign cursor_p1  = cursor_ext + CNT_W'(1);
   assign count_m1   = count_ff - CNT_W'(1);

   // Decode the command into the next count, cursor and chain action.
   always_comb begin
      ok         = 1'b0;
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      ctrl.mode  = MODE_HOLD;
      ctrl.slot  = '0;
      ctrl.value = req_value;
      case (cmd)
         CMD_INS_AFTER, CMD_INS_BEFORE: begin
            if (empty) begin
               ctrl.slot = '0;
            end else if (cmd == CMD_INS_AFTER) begin
               ctrl.slot = cursor_p1;
            end else begin
               ctrl.slot = cursor_ext;
            end
            if (!full) begin
               ok        = 1'b1;
               ctrl.mode = MODE_INSERT;
               count_in  = count_ff + CNT_W'(1);
               cursor_in = ctrl.slot[IDX_W-1:0];
            end
         end
         CMD_REMOVE: begin
            ctrl.slot = cursor_ext;
            if (!empty) begin
               ok        = 1'b1;
               ctrl.mode = MODE_REMOVE;
               count_in  = count_m1;
               // wrap to the start when the last item went away
               if (cursor_ext >= count_m1) begin
                  cursor_in = '0;
               end
            end
         end
         CMD_BEGIN: begin
            if (!empty) begin
               ok        = 1'b1;
               cursor_in = '0;
            end
         end
         CMD_END: begin
            if (!empty) begin
               ok        = 1'b1;
               cursor_in = count_m1[IDX_W-1:0];
            end
         end
         CMD_NEXT: begin
            if (!empty && cursor_p1 < count_ff) begin
               ok        = 1'b1;
               cursor_in = cursor_p1[IDX_W-1:0];
            end
         end
         CMD_PRIOR: begin
            if (!empty && cursor_ff != '0) begin
               ok        = 1'b1;
               cursor_in = cursor_ff - IDX_W'(1);
            end
         end
         CMD_MOVE: begin
            if (!empty && {1'b0, req_position} < count_ff) begin
               ok        = 1'b1;
               cursor_in = req_position;
            end
         end
         CMD_CLEAR: begin
            ok        = 1'b1;
            count_in  = '0;
            cursor_in = '0;
         end
         default: ok = 1'b0;
      endcase
      // Leave the chain untouched unless the item is really taken.
      if (!accept) begin
         ctrl.mode = MODE_HOLD;
      end
      ctrl.rd_old = cursor_ff;
      ctrl.rd_new = cursor_in;
   end

   cal_chain u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .old_value (old_value),
      .new_value (new_value)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff  <= count_in;
            cursor_ff <= cursor_in;
         end
      end
   end

   // Result payload; load on every accepted item.
   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff         <= ok;
         removed_ff    <= (ok && cmd == CMD_REMOVE) ? old_value : '0;
         cur_value_ff  <= (count_in != '0) ? new_value : '0;
         rsp_count_ff  <= count_in;
         rsp_cursor_ff <= cursor_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = ok_ff;
   assign rsp_tdata  = {1'b0,
                        (rsp_count_ff == CNT_W'(CAPACITY)),
                        (rsp_count_ff == '0),
                        rsp_cursor_ff,
                        rsp_count_ff,
                        cur_value_ff,
                        removed_ff};

endmodule

// ----- rtl/cal_checker.sv -----
// Port-level checks of the cursor list result channel, bound to the top level.
// Depends on cal_pkg and cursor_array_list_assert.svh.
`include "cursor_array_list_assert.svh"

module cal_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);
   import cal_pkg::*;

   logic [CNT_W-1:0] rsp_count;
   logic [IDX_W-1:0] rsp_cursor;
   logic             rsp_empty;
   logic             rsp_full;
   logic             flags_ok;
   logic             cursor_ok;

   assign rsp_count  = rsp_tdata[70:64];
   assign rsp_cursor = rsp_tdata[76:71];
   assign rsp_empty  = rsp_tdata[77];
   assign rsp_full   = rsp_tdata[78];

   assign flags_ok  = (rsp_empty == (rsp_count == '0)) &&
                      (rsp_full == (rsp_count == CNT_W'(CAPACITY)));
   assign cursor_ok = ({1'b0, rsp_cursor} < rsp_count) ||
                      (rsp_count == '0 && rsp_cursor == '0);

   // A held result keeps its payload until taken.
   `CAL_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // A result follows every accepted item.
   `CAL_ASSERT_NEXT(a_rsp_follows, req_tvalid && req_tready, rsp_tvalid)
   // Flags agree with the count.
   `CAL_ASSERT(a_flags, rsp_tvalid, flags_ok)
   // Cursor stays inside the list, and at zero when empty.
   `CAL_ASSERT(a_cursor, rsp_tvalid, cursor_ok)

endmodule

bind cursor_array_list cal_checker u_cal_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
